### sv/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// shared types, constants and helpers of the can signal packer
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int VALUE_W         = 32;
    localparam int DIV_W           = 12;
    localparam int FRAME_MAX_BITS  = 64;
    localparam int FRAME_BYTES_DEF = 8;
    localparam int MUL_W           = 14;

    // one signal request
    typedef struct packed {
        logic [31:0]        value;
        logic               conversion;
        logic [11:0]        scale_divisor;
        logic [2:0]         decimal_exponent;
        logic signed [15:0] offset;
        logic [2:0]         dest_byte;
        logic [2:0]         dest_bit;
        logic [5:0]         dest_length;
        logic               swap_bytes;
        logic               last;
    } t_csp_in;

    // one emitted frame
    typedef struct packed {
        logic [63:0] frame_data;
        logic        divide_error;
    } t_csp_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OFF,
        S_MUL,
        S_DIV,
        S_PACK
    } t_csp_state;

    // ten to the exponent, saturating at four
    function automatic logic [MUL_W-1:0] pow10(input logic [2:0] e);
        logic [MUL_W-1:0] r;
        unique case (e)
            3'd0:    r = MUL_W'(1);
            3'd1:    r = MUL_W'(10);
            3'd2:    r = MUL_W'(100);
            3'd3:    r = MUL_W'(1000);
            default: r = MUL_W'(10000);
        endcase
        return r;
    endfunction

endpackage

### sv/csp_div.sv
// ----------------------------------------------------------------------------
// csp_div
// restoring bit-serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module csp_div
    import csp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [VALUE_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(VALUE_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [VALUE_W-1:0] r_quo;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_den;

    logic [DIV_W:0]     rem_sh;
    logic [DIV_W:0]     diff;
    logic               ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[VALUE_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_W-2:0], ge};
            r_rem <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### sv/can_signal_packer.sv
// ----------------------------------------------------------------------------
// can_signal_packer
// packs converted signal values into one can frame
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_data) takes one signal
//   request at a time; o_in_ready is high only while the sequencer is idle.
//   output channel (o_out_valid / i_out_ready / o_out_data) carries the
//   frame and the divide error flag once the request marked last is packed.
// steps:
//   pass-through request: pack step, then ready again.
//   conversion with zero divisor: offset, multiply, then pack.
//   conversion: offset, multiply by ten to the exponent, then the divide
//   step (32 quotient bits plus the done strobe of the bit-serial divider),
//   then pack.
// reset:
//   frame cleared to all 0xff bytes, error flag cleared, no result pending.
// receiver stall:
//   a finished frame waits in the output register while new requests are
//   taken; only the next last request holds in its pack step until the
//   pending frame is taken.
// ----------------------------------------------------------------------------
module can_signal_packer
    import csp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_csp_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_csp_out o_out_data
);

    localparam int FRAME_W = FRAME_BYTES * 8;

    t_csp_state         r_state;
    t_csp_state         n_state;
    t_csp_in            r_item;
    logic [VALUE_W-1:0] r_val;
    logic [FRAME_W-1:0] r_frame;
    logic               r_err;
    logic               r_out_valid;
    t_csp_out           r_out_data;

    // sequencer outputs
    logic               accept;
    logic               div_start;
    logic               pack_go;

    // divider
    logic               div_done;
    logic [VALUE_W-1:0] div_quo;

    // datapath
    logic [15:0]                  off_mag;
    logic [VALUE_W-1:0]           off_val;
    logic [VALUE_W+MUL_W-1:0]     prod;
    logic [6:0]                   len_sum;
    logic [3:0]                   nbytes;
    logic [VALUE_W-1:0]           swp_val;
    logic [5:0]                   start_pos;
    logic [FRAME_MAX_BITS-1:0]    field64;
    logic [FRAME_MAX_BITS-1:0]    mask64;
    logic [FRAME_W-1:0]           new_frame;
    logic [FRAME_MAX_BITS-1:0]    frame_out;
    logic                         div_zero;

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_data.conversion ? S_OFF : S_PACK;
                end
            end
            S_OFF:  n_state = S_MUL;
            S_MUL:  n_state = div_zero ? S_PACK : S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_PACK;
                end
            end
            S_PACK: begin
                if (pack_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        accept     = o_in_ready && i_in_valid;
        div_start  = (r_state == S_MUL) && !div_zero;
        // a last request must not overwrite a frame still waiting
        pack_go    = (r_state == S_PACK) &&
                     !(r_item.last && r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------ conversion
    assign div_zero = (r_item.scale_divisor == '0);

    always_comb begin
        // negative offset: subtract its magnitude, floor at zero
        off_mag = 16'(16'd0 - r_item.offset);
        if (r_item.offset[15]) begin
            off_val = ({16'd0, off_mag} > r_val) ? '0 : r_val - {16'd0, off_mag};
        end else begin
            off_val = r_val + {16'd0, r_item.offset};
        end
        prod = r_val * pow10(r_item.decimal_exponent);
    end

    csp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod[VALUE_W-1:0]),
        .i_divisor  (r_item.scale_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // ------------------------------------------------------- swap and insert
    always_comb begin
        len_sum = {1'b0, r_item.dest_length} + 7'd7;
        nbytes  = len_sum[6:3];
        swp_val = r_val;
        if (r_item.swap_bytes) begin
            unique case (nbytes)
                4'd2:    swp_val = {16'd0, r_val[7:0], r_val[15:8]};
                4'd3:    swp_val = {8'd0, r_val[7:0], r_val[15:8], r_val[23:16]};
                4'd4:    swp_val = {r_val[7:0], r_val[15:8], r_val[23:16], r_val[31:24]};
                default: swp_val = r_val;
            endcase
        end
        start_pos = {r_item.dest_byte, r_item.dest_bit};
        // bits of the field beyond bit 31 are written as zeros
        field64   = {32'd0, swp_val} << start_pos;
        mask64    = ((64'd1 << r_item.dest_length) - 64'd1) << start_pos;
        new_frame = (r_frame & ~mask64[FRAME_W-1:0]) |
                    (field64[FRAME_W-1:0] & mask64[FRAME_W-1:0]);
        // bytes beyond the frame length read as 0xff
        frame_out = '1;
        frame_out[FRAME_W-1:0] = new_frame;
    end

    // -------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_data;
            r_val  <= i_in_data.value;
        end
        unique case (r_state)
            S_OFF:   r_val <= off_val;
            S_MUL:   r_val <= div_zero ? '1 : prod[VALUE_W-1:0];
            S_DIV:   if (div_done) r_val <= div_quo;
            default: ;
        endcase
        if (pack_go && r_item.last) begin
            r_out_data.frame_data   <= frame_out;
            r_out_data.divide_error <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '1;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_MUL && div_zero) begin
                r_err <= 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (pack_go) begin
                if (r_item.last) begin
                    r_frame     <= '1;
                    r_err       <= 1'b0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_frame <= new_frame;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------ assertions
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide step");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("request taken while previous one still in work");

    a_emit_from_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_PACK && r_item.last))
        else $error("frame emitted without a last request");

    a_frame_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pack_go && r_item.last) |=> (r_frame == '1 && !r_err))
        else $error("frame not refilled after emission");

endmodule
